// ===== rtl/core/bts_pkg.sv =====
// Shared constants and helpers for the bilinear texture sampler.
// No dependencies; imported by the sampler and its checker.
package bts_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int SZ_W     = 9;
  localparam int COORD_W  = 18;
  localparam int CH_W     = 8;
  localparam int OUT_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int IDX_W    = 13;
  localparam int WT_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [SZ_W-1:0] RESET_SIZE = 9'd256;
  localparam logic [OUT_W-1:0] OUT_MAX   = 16'd65280;

  // Map a size register onto 1..max.
  function automatic logic [SZ_W-1:0] eff_size(logic [SZ_W-1:0] sz, int max);
    if (sz == '0) return 9'd1;
    else if (int'(sz) > max) return SZ_W'(max);
    else return sz;
  endfunction

  // Clamp a signed index into 0..sz-1.
  function automatic logic [IDX_W-1:0] clamp_idx(logic signed [IDX_W-1:0] i,
                                                 logic [SZ_W-1:0] sz);
    logic signed [IDX_W-1:0] hi;
    hi = $signed({4'b0, sz - 9'd1});
    if (i < 0) return '0;
    else if (i > hi) return hi;
    else return i;
  endfunction

endpackage

// ===== rtl/core/bilinear_texture_sampler.sv =====
// Bilinear texture sampler: six-stage pipeline, four banked texel memories.
// Throughput: one transaction per cycle; busy never rises, no receiver stall.
// Texel writes land in the memory stage, so they keep program order with samples.
// Reset (synchronous, rst_n low) clears valid bits and sets both sizes to 256, capped at the maximum;
// texel memory contents are undefined until written.
module bilinear_texture_sampler #(
  parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_func,
  input  logic signed [bts_pkg::COORD_W-1:0]    in_coord_u,
  input  logic signed [bts_pkg::COORD_W-1:0]    in_coord_v,
  input  logic [7:0]                            in_texel_col,
  input  logic [7:0]                            in_texel_row,
  input  logic [bts_pkg::CH_W-1:0]              in_red,
  input  logic [bts_pkg::CH_W-1:0]              in_green,
  input  logic [bts_pkg::CH_W-1:0]              in_blue,
  output logic                                  out_strobe,
  output logic [bts_pkg::OUT_W-1:0]             out_red,
  output logic [bts_pkg::OUT_W-1:0]             out_green,
  output logic [bts_pkg::OUT_W-1:0]             out_blue,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bts_pkg::CFG_DAT_W-1:0]         cfg_data
);
  import bts_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int BCW = (CW > 1) ? CW - 1 : 1;
  localparam int BRW = (RW > 1) ? RW - 1 : 1;
  localparam int ABW = BCW + BRW;
  localparam int BANK_DEPTH = 1 << ABW;
  localparam int PROD_W = COORD_W + SZ_W + 1;
  localparam int SUM_W  = WT_W + CH_W + 2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Size registers, kept already mapped onto the legal range
  logic [SZ_W-1:0] eff_w_r, eff_h_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= eff_size(RESET_SIZE, MAX_WIDTH);
      eff_h_r <= eff_size(RESET_SIZE, MAX_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TEX_WIDTH)  eff_w_r <= eff_size(cfg_data, MAX_WIDTH);
      if (cfg_index == REG_TEX_HEIGHT) eff_h_r <= eff_size(cfg_data, MAX_HEIGHT);
    end
  end

  // Valid bits
  logic a_vld_r, b_vld_r, c_vld_r, c_wen_r, d_vld_r, e_vld_r, o_vld_r;
  logic a_func_r, b_func_r;
  logic c_wen_nxt;

  // Stage A: capture the transaction
  logic signed [COORD_W-1:0] a_u_r, a_v_r;
  logic [7:0] a_col_r, a_row_r, b_col_r, b_row_r;
  logic [3*CH_W-1:0] a_rgb_r, b_rgb_r, c_rgb_r;
  always_ff @(posedge clk) begin
    a_func_r <= in_func;
    a_u_r    <= in_coord_u;
    a_v_r    <= in_coord_v;
    a_col_r  <= in_texel_col;
    a_row_r  <= in_texel_row;
    a_rgb_r  <= {in_red, in_green, in_blue};
  end

  // Stage B: scale coordinates by the texture size
  logic signed [PROD_W-1:0] su_nxt, sv_nxt, b_su_r, b_sv_r;
  assign su_nxt = PROD_W'(a_u_r) * PROD_W'($signed({1'b0, eff_w_r}));
  assign sv_nxt = PROD_W'(a_v_r) * PROD_W'($signed({1'b0, eff_h_r}));
  always_ff @(posedge clk) begin
    b_su_r   <= su_nxt;
    b_sv_r   <= sv_nxt;
    b_func_r <= a_func_r;
    b_col_r  <= a_col_r;
    b_row_r  <= a_row_r;
    b_rgb_r  <= a_rgb_r;
  end

  // Stage C: floor, fraction and edge clamp
  logic signed [IDX_W-1:0] ix_nxt, iy_nxt;
  logic [CW-1:0] c_x0_r, c_x1_r, c_wcol_r;
  logic [RW-1:0] c_y0_r, c_y1_r, c_wrow_r;
  logic [7:0] c_fx_r, c_fy_r;
  assign ix_nxt = IDX_W'(b_su_r >>> 16);
  assign iy_nxt = IDX_W'(b_sv_r >>> 16);
  assign c_wen_nxt = b_vld_r && (b_func_r == FUNC_WRITE) &&
                     (int'(b_col_r) < MAX_WIDTH) && (int'(b_row_r) < MAX_HEIGHT);
  always_ff @(posedge clk) begin
    c_x0_r   <= CW'(clamp_idx(ix_nxt, eff_w_r));
    c_x1_r   <= CW'(clamp_idx(ix_nxt + 13'sd1, eff_w_r));
    c_y0_r   <= RW'(clamp_idx(iy_nxt, eff_h_r));
    c_y1_r   <= RW'(clamp_idx(iy_nxt + 13'sd1, eff_h_r));
    c_fx_r   <= b_su_r[15:8];
    c_fy_r   <= b_sv_r[15:8];
    c_wcol_r <= CW'(b_col_r);
    c_wrow_r <= RW'(b_row_r);
    c_rgb_r  <= b_rgb_r;
  end

  // Stage D: bank read/write and weights
  logic [3*CH_W-1:0] d_rd [4];
  logic d_x0p_r, d_x1p_r, d_y0p_r, d_y1p_r;
  logic [WT_W-1:0] d_wt_r [4];
  logic [8:0] wx0, wx1, wy0, wy1;
  assign wx0 = 9'd256 - {1'b0, c_fx_r};
  assign wx1 = {1'b0, c_fx_r};
  assign wy0 = 9'd256 - {1'b0, c_fy_r};
  assign wy1 = {1'b0, c_fy_r};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic XP = 1'(b & 1);
    localparam logic YP = 1'(b >> 1);
    logic [3*CH_W-1:0] mem [BANK_DEPTH];
    logic [3*CH_W-1:0] rd_r;
    logic [CW-1:0] xa;
    logic [RW-1:0] ya;
    logic [ABW-1:0] raddr, waddr;
    logic we;
    // Route whichever neighbor lands in this bank
    assign xa    = (c_x0_r[0] == XP) ? c_x0_r : c_x1_r;
    assign ya    = (c_y0_r[0] == YP) ? c_y0_r : c_y1_r;
    assign raddr = {BRW'(ya >> 1), BCW'(xa >> 1)};
    assign waddr = {BRW'(c_wrow_r >> 1), BCW'(c_wcol_r >> 1)};
    assign we    = c_wen_r && (c_wcol_r[0] == XP) && (c_wrow_r[0] == YP);
    always_ff @(posedge clk) begin
      if (we) mem[waddr] <= c_rgb_r;
      rd_r <= mem[raddr];
    end
    assign d_rd[b] = rd_r;
  end

  always_ff @(posedge clk) begin
    d_x0p_r   <= c_x0_r[0];
    d_x1p_r   <= c_x1_r[0];
    d_y0p_r   <= c_y0_r[0];
    d_y1p_r   <= c_y1_r[0];
    d_wt_r[0] <= WT_W'(wx0) * WT_W'(wy0);
    d_wt_r[1] <= WT_W'(wx1) * WT_W'(wy0);
    d_wt_r[2] <= WT_W'(wx0) * WT_W'(wy1);
    d_wt_r[3] <= WT_W'(wx1) * WT_W'(wy1);
  end

  // Stage E: weight each channel of each neighbor
  logic [3*CH_W-1:0] px [4];
  logic [WT_W+CH_W-1:0] e_prod_r [4][3];
  assign px[0] = d_rd[{d_y0p_r, d_x0p_r}];
  assign px[1] = d_rd[{d_y0p_r, d_x1p_r}];
  assign px[2] = d_rd[{d_y1p_r, d_x0p_r}];
  assign px[3] = d_rd[{d_y1p_r, d_x1p_r}];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        e_prod_r[k][c] <= (WT_W+CH_W)'(d_wt_r[k]) *
                          (WT_W+CH_W)'(px[k][CH_W*(2-c) +: CH_W]);
      end
    end
  end

  // Stage O: sum, round half up, drop the fraction byte
  logic [SUM_W-1:0] sum_nxt [3];
  logic [OUT_W-1:0] o_ch_r [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = SUM_W'(e_prod_r[0][c]) + SUM_W'(e_prod_r[1][c]) +
                   SUM_W'(e_prod_r[2][c]) + SUM_W'(e_prod_r[3][c]) + SUM_W'(128);
    end
  end
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) o_ch_r[c] <= sum_nxt[c][OUT_W+7:8];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      c_wen_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r && (b_func_r == FUNC_SAMPLE);
      c_wen_r <= c_wen_nxt;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      o_vld_r <= e_vld_r;
    end
  end

  assign out_strobe = o_vld_r;
  assign out_red    = o_ch_r[0];
  assign out_green  = o_ch_r[1];
  assign out_blue   = o_ch_r[2];

endmodule

// ===== rtl/core/bts_checker.sv =====
// Port-level checker for the bilinear texture sampler, bound to its top level.
// Depends on bts_pkg for field widths and function codes.
module bts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_func,
  input logic                          out_strobe,
  input logic [bts_pkg::OUT_W-1:0]     out_red,
  input logic [bts_pkg::OUT_W-1:0]     out_green,
  input logic [bts_pkg::OUT_W-1:0]     out_blue
);
  import bts_pkg::*;

  // Every sample transaction yields a result
  a_sample_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_SAMPLE) |-> ##6 out_strobe)
    else $error("sample transaction produced no result");

  // No result without a sample transaction behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(rst_n && start && !busy && in_func == FUNC_SAMPLE, 6))
    else $error("result without sample transaction");

  // Filtered channels stay on the byte scale
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_red <= OUT_MAX) && (out_green <= OUT_MAX) &&
                   (out_blue <= OUT_MAX))
    else $error("filtered channel out of range");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_func    (in_func),
  .out_strobe (out_strobe),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue)
);
